>>> hw/rtl/dbq_pkg.sv
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared constants, types and helper functions for the debounced button bank
// and quadrature decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbq_pkg;

  localparam int PIN_COUNT = 7;
  localparam int CNT_W     = 32;
  localparam int RUN_W     = 8;
  localparam int NUM_W     = $clog2(PIN_COUNT + 1);

  localparam logic [RUN_W-1:0] RUN_MAX       = 8'd255;
  localparam logic [RUN_W-1:0] THRESHOLD_RST = 8'd3;

  localparam int PIN_ENC_A   = 0;
  localparam int PIN_ENC_B   = 1;
  localparam int PIN_ENC_SW  = 2;
  localparam int PIN_BACK    = 3;
  localparam int PIN_HOME    = 4;
  localparam int PIN_RADIO   = 5;
  localparam int PIN_PROFILE = 6;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 208;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_BACK    = 3'd1,
    ACT_HOME    = 3'd2,
    ACT_SELECT  = 3'd3,
    ACT_RADIO   = 3'd4,
    ACT_PROFILE = 3'd5,
    ACT_NEXT    = 3'd6,
    ACT_PREV    = 3'd7
  } action_t;

  typedef logic signed [1:0] step_t;
  localparam step_t STEP_NONE = 2'sb00;
  localparam step_t STEP_FWD  = 2'sb01;
  localparam step_t STEP_REV  = 2'sb11;

  typedef struct packed {
    logic [PIN_COUNT-1:0] stable;
    logic [PIN_COUNT-1:0] changed;
    logic [NUM_W-1:0]     num_changed;
  } deb_status_t;

  typedef struct packed {
    logic             moved;
    step_t            step;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] step_total;
    logic [CNT_W-1:0] invalid_total;
  } quad_status_t;

  // Gray-code transition table, index is {prev, cur}
  function automatic step_t gray_step(input logic [1:0] prev, input logic [1:0] cur);
    step_t s;
    s = STEP_NONE;
    case ({prev, cur})
      4'h1, 4'h7, 4'hE, 4'h8: s = STEP_FWD;
      4'h2, 4'h4, 4'hB, 4'hD: s = STEP_REV;
      default:                s = STEP_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [NUM_W-1:0] popcount(input logic [PIN_COUNT-1:0] v);
    logic [NUM_W-1:0] c;
    c = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      c = c + NUM_W'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dbq_debounce.sv
// ----------------------------------------------------------------------------
// dbq_debounce
// Per-pin debounce bank: pending level, saturating run counter and stable
// level per pin, updated once per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_debounce (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [dbq_pkg::PIN_COUNT-1:0] active,
  input  wire logic [dbq_pkg::RUN_W-1:0]     threshold,
  output dbq_pkg::deb_status_t               status
);
  import dbq_pkg::*;

  logic [PIN_COUNT-1:0] pending;
  logic [PIN_COUNT-1:0] level;
  logic [RUN_W-1:0]     run_cnt      [PIN_COUNT];
  logic [PIN_COUNT-1:0] level_next;
  logic [RUN_W-1:0]     run_cnt_next [PIN_COUNT];
  logic [RUN_W-1:0]     run_tmp      [PIN_COUNT];
  logic [PIN_COUNT-1:0] flip;

  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (active[i] == pending[i]) begin
        run_tmp[i] = (run_cnt[i] == RUN_MAX) ? run_cnt[i] : run_cnt[i] + RUN_W'(1);
      end else begin
        run_tmp[i] = RUN_W'(1);
      end
      flip[i]         = (run_tmp[i] >= threshold) && (active[i] != level[i]);
      level_next[i]   = flip[i] ? active[i] : level[i];
      run_cnt_next[i] = flip[i] ? '0 : run_tmp[i];
    end
  end

  assign status.stable      = level_next;
  assign status.changed     = flip;
  assign status.num_changed = popcount(flip);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      level   <= '0;
      for (int i = 0; i < PIN_COUNT; i++) begin
        run_cnt[i] <= '0;
      end
    end else if (en) begin
      pending <= active;
      level   <= level_next;
      for (int i = 0; i < PIN_COUNT; i++) begin
        run_cnt[i] <= run_cnt_next[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dbq_quad.sv
// ----------------------------------------------------------------------------
// dbq_quad
// Quadrature decoder on the debounced A/B pair: position, step and invalid
// step counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_quad (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire dbq_pkg::deb_status_t deb,
  output dbq_pkg::quad_status_t     status
);
  import dbq_pkg::*;

  logic [1:0]       prev_quad;
  logic             seen;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] invalid_cnt;

  logic [1:0]       cur;
  logic [1:0]       prev_eff;
  logic             moved;
  step_t            step;
  logic [1:0]       prev_quad_next;
  logic [CNT_W-1:0] position_next;
  logic [CNT_W-1:0] step_cnt_next;
  logic [CNT_W-1:0] invalid_cnt_next;

  always_comb begin
    cur            = {deb.stable[PIN_ENC_A], deb.stable[PIN_ENC_B]};
    prev_eff       = seen ? prev_quad : cur;
    moved          = deb.changed[PIN_ENC_A] | deb.changed[PIN_ENC_B];
    step           = moved ? gray_step(prev_eff, cur) : STEP_NONE;
    prev_quad_next = moved ? cur : prev_eff;
    step_cnt_next  = moved ? step_cnt + CNT_W'(1) : step_cnt;
    invalid_cnt_next = (moved && step == STEP_NONE) ? invalid_cnt + CNT_W'(1)
                                                    : invalid_cnt;
    position_next  = position + {{(CNT_W-2){step[1]}}, step};
  end

  assign status.moved         = moved;
  assign status.step          = step;
  assign status.position      = position_next;
  assign status.step_total    = step_cnt_next;
  assign status.invalid_total = invalid_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_quad   <= '0;
      seen        <= 1'b0;
      position    <= '0;
      step_cnt    <= '0;
      invalid_cnt <= '0;
    end else if (en) begin
      prev_quad   <= prev_quad_next;
      seen        <= 1'b1;
      position    <= position_next;
      step_cnt    <= step_cnt_next;
      invalid_cnt <= invalid_cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/debounced_buttons_quadrature_decoder_core.sv
// ----------------------------------------------------------------------------
// debounced_buttons_quadrature_decoder_core
// Debounced button bank with quadrature decoder and priority action picker.
//
//   channel  dir  width       contents
//   s_*      in   tdata 40    one poll tick: raw pins, timestamp
//   m_*      out  tdata 208   debounced levels, counters, position
//                 tuser 3     action kind
//   cfg_*    in   wdata 8     debounce threshold
//
// One transaction per clock unless the output stalls (input register, result
// register). The state update and result are formed in one pass between them.
// Reset clears all pin, decoder and counter state; threshold returns to 3.
// A stalled result register holds while the input register keeps its item;
// input is taken whenever the input register is empty or moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_buttons_quadrature_decoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dbq_pkg::RUN_W-1:0]      cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // raw_pins[6:0], now_ms[38:7], zero pad
  input  wire logic [dbq_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // stable_levels[6:0], changed_mask[13:7], nav_delta[15:14],
  // encoder_position[47:16], encoder_detents[77:48], encoder_step_total[109:78],
  // encoder_invalid_total[141:110], change_total[173:142],
  // last_change_ms[205:174], zero pad
  output logic [dbq_pkg::OUT_DATA_W-1:0]      m_tdata,
  // action_kind[2:0]
  output logic [2:0]                          m_tuser
);
  import dbq_pkg::*;

  logic [RUN_W-1:0]     threshold;

  logic                 in_valid;
  logic [PIN_COUNT-1:0] in_raw;
  logic [CNT_W-1:0]     in_now;
  logic                 advance;

  deb_status_t          deb;
  quad_status_t         quad;

  logic [CNT_W-1:0]     change_cnt;
  logic [CNT_W-1:0]     last_time;
  logic [CNT_W-1:0]     change_cnt_next;
  logic [CNT_W-1:0]     last_time_next;
  logic [PIN_COUNT-1:0] press;
  action_t              kind_next;
  step_t                nav_next;

  logic                 out_valid;
  logic [PIN_COUNT-1:0] out_stable;
  logic [PIN_COUNT-1:0] out_changed;
  action_t              out_kind;
  step_t                out_nav;
  logic [CNT_W-1:0]     out_pos;
  logic [CNT_W-1:0]     out_step;
  logic [CNT_W-1:0]     out_inv;
  logic [CNT_W-1:0]     out_chg;
  logic [CNT_W-1:0]     out_last;
  logic [CNT_W-1:0]     det_sum;
  logic [CNT_W-1:0]     u_quad_step_ref;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata[PIN_COUNT-1:0];
      in_now <= s_tdata[PIN_COUNT +: CNT_W];
    end
  end

  dbq_debounce u_debounce (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .active    (~in_raw),
    .threshold (threshold),
    .status    (deb)
  );

  dbq_quad u_quad (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .deb    (deb),
    .status (quad)
  );

  always_comb begin
    press           = deb.changed & deb.stable;
    change_cnt_next = change_cnt + CNT_W'(deb.num_changed);
    last_time_next  = (|deb.changed) ? in_now : last_time;
    nav_next        = STEP_NONE;
    if (press[PIN_BACK]) begin
      kind_next = ACT_BACK;
    end else if (press[PIN_HOME]) begin
      kind_next = ACT_HOME;
    end else if (press[PIN_ENC_SW]) begin
      kind_next = ACT_SELECT;
    end else if (deb.changed[PIN_RADIO]) begin
      kind_next = ACT_RADIO;
    end else if (deb.changed[PIN_PROFILE]) begin
      kind_next = ACT_PROFILE;
    end else if (quad.step == STEP_FWD) begin
      kind_next = ACT_NEXT;
      nav_next  = STEP_FWD;
    end else if (quad.step == STEP_REV) begin
      kind_next = ACT_PREV;
      nav_next  = STEP_REV;
    end else begin
      kind_next = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_cnt <= '0;
      last_time  <= '0;
    end else if (advance) begin
      change_cnt <= change_cnt_next;
      last_time  <= last_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stable  <= deb.stable;
      out_changed <= deb.changed;
      out_kind    <= kind_next;
      out_nav     <= nav_next;
      out_pos     <= quad.position;
      out_step    <= quad.step_total;
      out_inv     <= quad.invalid_total;
      out_chg     <= change_cnt_next;
      out_last    <= last_time_next;
    end
  end

  // truncation toward zero: bias negatives by 3 before the arithmetic shift
  assign det_sum = out_pos + (out_pos[CNT_W-1] ? CNT_W'(3) : CNT_W'(0));

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {2'b00, out_last, out_chg, out_inv, out_step,
                     det_sum[CNT_W-1:2], out_pos, out_nav, out_changed, out_stable};

  ap_nav_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == ACT_NEXT) == (out_nav == STEP_FWD)) &&
                  ((out_kind == ACT_PREV) == (out_nav == STEP_REV)))
    else $error("nav_delta disagrees with action kind");

  ap_change_total_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && deb.changed == '0) |=> change_cnt == $past(change_cnt))
    else $error("change total moved without a debounced transition");

  ap_step_total_bumps: assert property (@(posedge clk) disable iff (rst)
    (advance && quad.moved) |=> out_step == $past(u_quad_step_ref) + CNT_W'(1))
    else $error("step total did not advance on an encoder transition");

  ap_result_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && !advance) |=> $stable(out_pos) && $stable(out_chg))
    else $error("result register changed while stalled");

  assign u_quad_step_ref = quad.step_total - CNT_W'(1);

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the debounced button bank and quadrature decoder.
// A queue of poll ticks feeds a bursty stream driver. Each accepted tick runs
// through a local model of the debouncers, the Gray decoder and the action
// priority. The monitor compares every result, field by field, against the
// oldest prediction while the receiver stalls on its own pattern. Phases run
// at several debounce thresholds: 1, 3, 2, 255, 0 and a random small value.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dbq_pkg::*;

  typedef struct packed {
    logic [6:0]  pins;
    logic [31:0] ms;
  } tick_t;

  typedef struct packed {
    logic [6:0]  stable;
    logic [6:0]  changed;
    action_t     kind;
    logic [1:0]  nav;
    logic [31:0] position;
    logic [29:0] detents;
    logic [31:0] steps;
    logic [31:0] invalids;
    logic [31:0] changes;
    logic [31:0] last_ms;
  } tick_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [RUN_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;

  debounced_buttons_quadrature_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  tick_t        tick_queue[$];
  tick_result_t expected_ticks[$];
  int           mismatch_count = 0;
  int           checked_count = 0;

  // model state
  logic [7:0]  threshold = THRESHOLD_RST;
  logic [6:0]  pend_lvl = '0;
  logic [6:0]  deb_lvl = '0;
  logic [7:0]  run_cnt [7];
  logic [1:0]  prev_ab = '0;
  logic        ab_seen = 1'b0;
  logic [31:0] pos_acc = '0;
  logic [31:0] step_cnt = '0;
  logic [31:0] invalid_cnt = '0;
  logic [31:0] change_cnt = '0;
  logic [31:0] last_ms = '0;

  initial begin
    for (int i = 0; i < 7; i++) run_cnt[i] = '0;
  end

  // position of a {A,B} level pair along the forward Gray sequence
  function automatic logic [1:0] gray_index(input logic [1:0] ab);
    return {ab[1], ab[1] ^ ab[0]};
  endfunction

  task automatic predict_tick(input logic [6:0] raw_pins, input logic [31:0] now);
    tick_result_t r;
    logic [6:0]  chg;
    logic        lvl;
    logic [1:0]  cur;
    logic [1:0]  gray_dist;
    int          move;
    logic signed [31:0] spos;
    logic signed [31:0] q;
    chg = '0;
    move = 0;
    for (int i = 0; i < 7; i++) begin
      lvl = ~raw_pins[i];
      if (lvl == pend_lvl[i]) begin
        if (run_cnt[i] != RUN_MAX) run_cnt[i] = run_cnt[i] + 8'd1;
      end else begin
        pend_lvl[i] = lvl;
        run_cnt[i] = 8'd1;
      end
      if (run_cnt[i] >= threshold && lvl != deb_lvl[i]) begin
        deb_lvl[i] = lvl;
        run_cnt[i] = '0;
        chg[i] = 1'b1;
      end
    end
    cur = {deb_lvl[PIN_ENC_A], deb_lvl[PIN_ENC_B]};
    if (!ab_seen) begin
      prev_ab = cur;
      ab_seen = 1'b1;
    end
    if (chg[PIN_ENC_A] || chg[PIN_ENC_B]) begin
      step_cnt = step_cnt + 32'd1;
      gray_dist = gray_index(cur) - gray_index(prev_ab);
      if (gray_dist == 2'd1) move = 1;
      else if (gray_dist == 2'd3) move = -1;
      else invalid_cnt = invalid_cnt + 32'd1;
      pos_acc = pos_acc + 32'(move);
      prev_ab = cur;
    end
    if (chg != '0) begin
      last_ms = now;
      change_cnt = change_cnt + 32'($countones(chg));
    end
    r.nav = 2'b00;
    if (chg[PIN_BACK] && deb_lvl[PIN_BACK]) r.kind = ACT_BACK;
    else if (chg[PIN_HOME] && deb_lvl[PIN_HOME]) r.kind = ACT_HOME;
    else if (chg[PIN_ENC_SW] && deb_lvl[PIN_ENC_SW]) r.kind = ACT_SELECT;
    else if (chg[PIN_RADIO]) r.kind = ACT_RADIO;
    else if (chg[PIN_PROFILE]) r.kind = ACT_PROFILE;
    else if (move > 0) begin
      r.kind = ACT_NEXT;
      r.nav = 2'b01;
    end else if (move < 0) begin
      r.kind = ACT_PREV;
      r.nav = 2'b11;
    end else r.kind = ACT_NONE;
    spos = pos_acc;
    q = spos / 32'sd4;
    r.stable = deb_lvl;
    r.changed = chg;
    r.position = pos_acc;
    r.detents = q[29:0];
    r.steps = step_cnt;
    r.invalids = invalid_cnt;
    r.changes = change_cnt;
    r.last_ms = last_ms;
    expected_ticks.push_back(r);
  endtask

  // driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    tick_t item;
    logic  nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) predict_tick(s_tdata[6:0], s_tdata[38:7]);
      if (!s_tvalid || s_tready) begin
        nxt = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_queue.size() != 0) begin
          item = tick_queue.pop_front();
          s_tdata <= {1'b0, item.ms, item.pins};
          nxt = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        s_tvalid <= nxt;
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  logic [31:0] rx_cycle = '0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle = rx_cycle + 32'd1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && checked_count > 100 && tick_queue.size() > 40) begin
        hold_left = 120;
        hold_done = 1'b1;
        rdy = 1'b0;
      end else begin
        case (rx_cycle[10:8])
          3'd0, 3'd1: rdy = 1'b1;
          3'd2:       rdy = 1'($urandom_range(0, 1));
          3'd3:       rdy = (rx_cycle[2:0] != 3'd0);
          3'd4:       rdy = ($urandom_range(0, 3) == 0);
          3'd5:       rdy = rx_cycle[3];
          default:    rdy = ($urandom_range(0, 3) != 0);
        endcase
      end
      m_tready <= rdy;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    tick_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_ticks.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatch_count++;
      end else begin
        e = expected_ticks.pop_front();
        checked_count++;
        check_field("stable_levels", 32'(e.stable), 32'(m_tdata[6:0]));
        check_field("changed_mask", 32'(e.changed), 32'(m_tdata[13:7]));
        check_field("action_kind", 32'(e.kind), 32'(m_tuser));
        check_field("nav_delta", 32'(e.nav), 32'(m_tdata[15:14]));
        check_field("encoder_position", e.position, m_tdata[47:16]);
        check_field("encoder_detents", 32'(e.detents), 32'(m_tdata[77:48]));
        check_field("encoder_step_total", e.steps, m_tdata[109:78]);
        check_field("encoder_invalid_total", e.invalids, m_tdata[141:110]);
        check_field("change_total", e.changes, m_tdata[173:142]);
        check_field("last_change_ms", e.last_ms, m_tdata[205:174]);
      end
    end
  end

  task automatic queue_tick(input logic [6:0] pins, input logic [31:0] ms);
    tick_queue.push_back({pins, ms});
  endtask

  task automatic wait_idle();
    while (tick_queue.size() != 0 || s_tvalid || expected_ticks.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = value;
  endtask

  // mostly well-formed runs: encoder walks the Gray sequence, keys toggle,
  // each level held long enough to pass the debouncer; some glitches
  task automatic queue_random_run(input int count, input int thr);
    logic [1:0] enc_idx;
    logic [1:0] ab;
    logic [4:0] keys;
    logic [6:0] pins;
    logic       fwd;
    int         hold;
    int         left;
    int         mode;
    enc_idx = '0;
    keys = '1;
    fwd = 1'b1;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        if ($urandom_range(0, 7) == 0) fwd = !fwd;
        if ($urandom_range(0, 2) != 0) enc_idx = fwd ? enc_idx + 2'd1 : enc_idx - 2'd1;
        if ($urandom_range(0, 3) == 0) keys[3'($urandom_range(0, 4))] ^= 1'b1;
        ab = {enc_idx[1], enc_idx[1] ^ enc_idx[0]};
        pins = {keys, ~ab[0], ~ab[1]};
        hold = ((thr < 1) ? 1 : thr) + $urandom_range(0, 2);
      end else if (mode < 9) begin
        pins = 7'($urandom_range(0, 127));
        hold = 1;
      end else begin
        pins = 7'($urandom_range(0, 127));
        hold = $urandom_range(1, thr + 2);
      end
      while (hold > 0 && left > 0) begin
        queue_tick(pins, $urandom);
        hold--;
        left--;
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, threshold 1: first-tick decode, both rotations, invalid
    // steps, every action and the priority between them
    write_threshold(8'd1);
    queue_tick(7'h7E, 32'h0000_0000);
    queue_tick(7'h7F, 32'hFFFF_FFFF);
    queue_tick(7'h7E, $urandom);
    queue_tick(7'h7C, $urandom);
    queue_tick(7'h7D, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h7D, $urandom);
    queue_tick(7'h7C, $urandom);
    queue_tick(7'h7E, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h7C, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h00, 32'hFFFF_FFFF);
    queue_tick(7'h7F, 32'h0000_0000);
    queue_tick(7'h6B, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h7B, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h3F, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h5F, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h7A, $urandom);
    queue_tick(7'h7F, $urandom);
    queue_tick(7'h1F, $urandom);
    queue_tick(7'h7F, $urandom);

    write_threshold(8'd3);
    queue_random_run(80, 3);

    write_threshold(8'd2);
    queue_random_run(80, 2);

    // max threshold: run counters saturate while idle, then all pins flip
    write_threshold(8'd255);
    for (int i = 0; i < 265; i++) queue_tick(7'h7F, $urandom);
    for (int i = 0; i < 260; i++) queue_tick(7'h00, $urandom);
    for (int i = 0; i < 5; i++) queue_tick(7'h7F, $urandom);

    // zero threshold: any differing sample is taken at once
    write_threshold(8'd0);
    queue_random_run(40, 0);

    write_threshold(8'($urandom_range(1, 8)));
    queue_random_run(60, int'(threshold));

    write_threshold(8'd1);
    queue_random_run(40, 1);

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_ticks.size() != 0) begin
      $error("%0d predicted results never arrived", expected_ticks.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
